// File: rtl/pls_pkg.sv
// shared constants and codes for the positional list store
package pls_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int ST_W     = 2;
  localparam int IN_W     = ((CMD_W + VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W    = ((VAL_W + ST_W + CNT_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DEL_AT     = 3'd6;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

endpackage

// File: rtl/positional_list_store_unit.sv
// bounded ordered list of signed 32-bit values with positional commands
//
// Input stream (s_tvalid/s_tready/s_tdata) carries one command word: read at a
// position, push front or back, insert after a position, delete front, back or
// at a position. Each command word yields exactly one result word on the
// output stream (m_tvalid/m_tready/m_tdata): the value read, a status
// (ok, empty, full, bad position) and the element count after the command.
// A rejected command leaves the list unchanged.
//
// The command sits in an input register, then the cell row shifts or selects
// in parallel while the result register loads. One command is accepted every
// cycle while the receiver takes result words; the list update of one command
// is complete before the next one is evaluated.
//
// Reset empties the list (count to zero) and drops any word in flight; cell
// contents are not cleared, only cells below the count are ever read.
// When the receiver stalls, the result register holds, the input register
// fills, and s_tready falls until the result word is taken.
module positional_list_store_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // command[2:0], value[34:3], position[39:35]
  input  logic [pls_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // read_value[31:0], status[33:32], count[38:34], zero pad above
  output logic [pls_pkg::OUT_W-1:0] m_tdata
);
  import pls_pkg::*;

  // input register
  logic             in_valid;
  logic [CMD_W-1:0] in_cmd;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;

  // result register
  logic             out_valid;
  logic [VAL_W-1:0] out_read;
  status_t          out_status;
  logic [CNT_W-1:0] out_count;

  // list state
  logic [VAL_W-1:0] store [CAPACITY];
  logic [VAL_W-1:0] store_next [CAPACITY];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             out_free;
  logic             advance;
  logic             do_ins;
  logic             do_del;
  logic [IDX_W-1:0] at;
  logic [VAL_W-1:0] read_next;
  status_t          status_next;
  logic             is_empty;
  logic             is_full;
  logic             pos_bad_rd;
  logic             pos_bad_ins;
  logic [POS_W-1:0] pos_m1;
  logic [CNT_W-1:0] count_m1;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  assign is_empty    = (count == '0);
  assign is_full     = (32'(count) >= CAPACITY);
  assign pos_bad_rd  = (in_pos == '0) || (32'(in_pos) > 32'(count));
  assign pos_bad_ins = (32'(in_pos) > 32'(count));
  assign pos_m1      = in_pos - POS_W'(1);
  assign count_m1    = count - CNT_W'(1);

  // command decode: gap position and kind of shift
  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    at          = '0;
    read_next   = '0;
    status_next = ST_OK;
    unique case (in_cmd)
      CMD_READ: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (pos_bad_rd) begin
          status_next = ST_BADPOS;
        end else begin
          read_next = store[pos_m1[IDX_W-1:0]];
        end
      end
      CMD_PUSH_FRONT, CMD_APPEND, CMD_INSERT: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else if (in_cmd == CMD_PUSH_FRONT) begin
          do_ins = 1'b1;
        end else if (in_cmd == CMD_APPEND) begin
          do_ins = 1'b1;
          at     = count[IDX_W-1:0];
        end else if (pos_bad_ins) begin
          status_next = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          at     = in_pos[IDX_W-1:0];
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else if (in_cmd == CMD_DEL_FRONT) begin
          do_del = 1'b1;
        end else if (in_cmd == CMD_DEL_BACK) begin
          do_del = 1'b1;
          at     = count_m1[IDX_W-1:0];
        end else if (pos_bad_rd) begin
          status_next = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          at     = pos_m1[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // each cell takes its neighbor, the new value, or holds
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      store_next[i] = store[i];
      if (do_ins) begin
        if (IDX_W'(i) == at) begin
          store_next[i] = in_value;
        end else if (IDX_W'(i) > at && i > 0) begin
          store_next[i] = store[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (IDX_W'(i) >= at && i + 1 < CAPACITY) begin
          store_next[i] = store[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_del) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tdata[CMD_W-1:0];
      in_value <= s_tdata[CMD_W +: VAL_W];
      in_pos   <= s_tdata[CMD_W + VAL_W +: POS_W];
    end
    if (advance) begin
      store      <= store_next;
      out_read   <= read_next;
      out_status <= status_next;
      out_count  <= count_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_count, out_status, out_read});

  // the list never grows past its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("element count above capacity");

  // a full report only when the list really is full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_FULL |-> 32'(out_count) == CAPACITY)
    else $error("full status with room left");

  // an empty report only when the list holds nothing
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_EMPTY |-> out_count == '0)
    else $error("empty status with elements held");

  // count moves by at most one per command and only when one completes
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(count))
    else $error("count changed without a command");

  // a rejected command leaves the count alone
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    advance && status_next != ST_OK |=> count == $past(count))
    else $error("rejected command changed the list");

endmodule
